[sv/rgfr_pkg.sv]
// Shared types and codes for the relay group forwarding router.
// Used by the channel interfaces, the controller, the datapath and the top level.
`default_nettype none

package rgfr_pkg;

    localparam int PEER_W = 64;
    localparam int UID_W  = 32;
    localparam int TAG_W  = 16;

    // request types
    localparam logic [1:0] REQ_PACKET = 2'd0;
    localparam logic [1:0] REQ_CLEAR  = 2'd1;
    localparam logic [1:0] REQ_ADD    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNAUTH = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_CFG    = 2'd3;

    // source of the destination carried by a result word
    typedef enum logic [1:0] {
        SEL_NONE,
        SEL_MCAST,
        SEL_UCAST
    } t_sel;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       auth_clear;
        logic       auth_start;
        logic       auth_step;
        logic       auth_write;
        logic       mcast_update;
        logic       u_start;
        logic       u_look_step;
        logic       shift_start;
        logic       shift_step;
        logic       u_insert;
        logic       u_read;
        logic       emit;
        t_sel       emit_sel;
        logic [1:0] emit_status;
        logic       emit_last;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [1:0] req;
        logic       uid_odd;
        logic       auth_req;
        logic       auth_done;
        logic       auth_hit;
        logic       auth_free;
        logic       look_done;
        logic       u_found;
        logic       u_full;
        logic       u_empty;
        logic       shift_done;
        logic       emit_last;
        logic       out_free;
    } t_stat;

endpackage

`default_nettype wire

[sv/rgfr_in_if.sv]
// Input channel of the router: one request word with valid/ready.
// Depends on rgfr_pkg for field widths.
`default_nettype none

interface rgfr_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   req_type;
    logic [rgfr_pkg::PEER_W-1:0]  peer_id;
    logic [rgfr_pkg::UID_W-1:0]   uid;
    logic [rgfr_pkg::TAG_W-1:0]   packet_tag;

    modport source (output valid, req_type, peer_id, uid, packet_tag, input ready);
    modport sink   (input valid, req_type, peer_id, uid, packet_tag, output ready);
endinterface

`default_nettype wire

[sv/rgfr_out_if.sv]
// Output channel of the router: one forwarding result word with valid/ready.
// Depends on rgfr_pkg for field widths.
`default_nettype none

interface rgfr_out_if;
    logic                         valid;
    logic                         ready;
    logic [rgfr_pkg::PEER_W-1:0]  dest_peer;
    logic                         has_dest;
    logic [rgfr_pkg::TAG_W-1:0]   out_tag;
    logic [1:0]                   status;
    logic                         last;

    modport source (output valid, dest_peer, has_dest, out_tag, status, last, input ready);
    modport sink   (input valid, dest_peer, has_dest, out_tag, status, last, output ready);
endinterface

`default_nettype wire

[sv/rgfr_ctrl.sv]
// Controller of the router: sequences the authorized list scan, unicast lookup,
// sorted insert and result emission. Depends on rgfr_pkg command/status types.
`default_nettype none

module rgfr_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire rgfr_pkg::t_stat i_stat,
    output rgfr_pkg::t_cmd       o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_AUTH,
        S_PKT,
        S_ULOOK,
        S_USHIFT,
        S_EMIT_RD,
        S_EMIT_WR,
        S_RESULT
    } t_state;

    t_state         r_state, n_state;
    logic [1:0]     r_st, n_st;
    rgfr_pkg::t_sel r_sel, n_sel;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.emit_sel = rgfr_pkg::SEL_NONE;
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                n_sel = rgfr_pkg::SEL_NONE;
                unique case (i_stat.req)
                    rgfr_pkg::REQ_CLEAR: begin
                        o_cmd.auth_clear = 1'b1;
                        n_st    = rgfr_pkg::ST_CFG;
                        n_state = S_RESULT;
                    end
                    rgfr_pkg::REQ_ADD: begin
                        o_cmd.auth_start = 1'b1;
                        n_state = S_AUTH;
                    end
                    rgfr_pkg::REQ_PACKET: begin
                        if (i_stat.auth_req) begin
                            o_cmd.auth_start = 1'b1;
                            n_state = S_AUTH;
                        end else begin
                            n_state = S_PKT;
                        end
                    end
                    default: begin
                        n_st    = rgfr_pkg::ST_OK;
                        n_state = S_RESULT;
                    end
                endcase
            end
            S_AUTH: begin
                o_cmd.auth_step = 1'b1;
                if (i_stat.auth_done) begin
                    if (i_stat.req == rgfr_pkg::REQ_ADD) begin
                        n_state = S_RESULT;
                        if (i_stat.auth_hit) begin
                            n_st = rgfr_pkg::ST_CFG;
                        end else if (i_stat.auth_free) begin
                            o_cmd.auth_write = 1'b1;
                            n_st = rgfr_pkg::ST_CFG;
                        end else begin
                            n_st = rgfr_pkg::ST_FULL;
                        end
                    end else if (i_stat.auth_hit) begin
                        n_state = S_PKT;
                    end else begin
                        n_st    = rgfr_pkg::ST_UNAUTH;
                        n_state = S_RESULT;
                    end
                end
            end
            S_PKT: begin
                o_cmd.u_start = 1'b1;
                if (!i_stat.uid_odd) begin
                    o_cmd.mcast_update = 1'b1;
                    if (i_stat.u_empty) begin
                        n_st    = rgfr_pkg::ST_OK;
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_EMIT_RD;
                    end
                end else begin
                    n_state = S_ULOOK;
                end
            end
            S_ULOOK: begin
                o_cmd.u_look_step = 1'b1;
                if (i_stat.look_done) begin
                    n_sel = rgfr_pkg::SEL_MCAST;
                    if (i_stat.u_found) begin
                        n_st    = rgfr_pkg::ST_OK;
                        n_state = S_RESULT;
                    end else if (i_stat.u_full) begin
                        n_st    = rgfr_pkg::ST_FULL;
                        n_state = S_RESULT;
                    end else begin
                        o_cmd.shift_start = 1'b1;
                        n_state = S_USHIFT;
                    end
                end
            end
            S_USHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_done) begin
                    o_cmd.u_insert = 1'b1;
                    n_st    = rgfr_pkg::ST_OK;
                    n_state = S_RESULT;
                end
            end
            S_EMIT_RD: begin
                o_cmd.u_read = 1'b1;
                n_state = S_EMIT_WR;
            end
            S_EMIT_WR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_sel    = rgfr_pkg::SEL_UCAST;
                    o_cmd.emit_status = rgfr_pkg::ST_OK;
                    o_cmd.emit_last   = i_stat.emit_last;
                    n_state = i_stat.emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit        = 1'b1;
                    o_cmd.emit_sel    = r_sel;
                    o_cmd.emit_status = r_st;
                    o_cmd.emit_last   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= rgfr_pkg::ST_OK;
            r_sel   <= rgfr_pkg::SEL_NONE;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
            r_sel   <= n_sel;
        end
    end

    a_load_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_DISPATCH)
        else $error("accepted word not dispatched");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit && o_cmd.emit_last) |=> r_state == S_IDLE)
        else $error("final result did not return to idle");

    a_one_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.auth_step, o_cmd.u_look_step, o_cmd.shift_step, o_cmd.u_read}))
        else $error("two table walks at once");

endmodule

`default_nettype wire

[sv/rgfr_datapath.sv]
// Datapath of the router: request capture, authorized list memory, sorted unicast
// table memory, multicast slot and the output register. Depends on rgfr_pkg and the
// channel interfaces.
`default_nettype none

module rgfr_datapath #(
    parameter int AUTH_DEPTH  = 16,
    parameter int UCAST_DEPTH = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_wdata,
    rgfr_in_if.sink              i_in,
    rgfr_out_if.source           o_out,
    input  wire rgfr_pkg::t_cmd  i_cmd,
    output rgfr_pkg::t_stat      o_stat
);

    localparam int PW   = rgfr_pkg::PEER_W;
    localparam int UIDW = rgfr_pkg::UID_W;
    localparam int TW   = rgfr_pkg::TAG_W;
    localparam int EW   = UIDW + PW;
    localparam int AW   = (AUTH_DEPTH > 1) ? $clog2(AUTH_DEPTH) : 1;
    localparam int AIW  = AW + 1;
    localparam int UW   = (UCAST_DEPTH > 1) ? $clog2(UCAST_DEPTH) : 1;
    localparam int UIW  = UW + 1;
    localparam logic [AIW-1:0] A_DEPTH = AIW'(AUTH_DEPTH);
    localparam logic [UIW-1:0] U_DEPTH = UIW'(UCAST_DEPTH);

    // configuration
    logic r_auth_req;

    // captured request word
    logic [1:0]      r_req;
    logic [PW-1:0]   r_peer;
    logic [UIDW-1:0] r_uid;
    logic [TW-1:0]   r_tag;

    // authorized list
    logic [PW-1:0]         r_auth_mem [AUTH_DEPTH];
    logic [PW-1:0]         r_auth_rdata;
    logic [AUTH_DEPTH-1:0] r_auth_valid;
    logic [AIW-1:0]        r_a_idx;
    logic                  r_a_pend;
    logic [AW-1:0]         r_a_pidx;
    logic                  r_a_hit;
    logic                  r_a_free;
    logic [AW-1:0]         r_a_fidx;
    logic                  w_a_rd;
    logic [AW-1:0]         w_a_addr;
    logic                  w_a_done;

    // multicast slot
    logic            r_m_valid;
    logic [UIDW-1:0] r_m_uid;
    logic [PW-1:0]   r_m_peer;

    // unicast table, kept sorted by uid in entries below r_u_cnt
    logic [EW-1:0]   r_u_mem [UCAST_DEPTH];
    logic [EW-1:0]   r_u_rdata;
    logic [UIW-1:0]  r_u_cnt;
    logic [UIW-1:0]  r_u_idx;
    logic            r_u_pend;
    logic [UW-1:0]   r_u_pidx;
    logic            r_u_found;
    logic [UIW-1:0]  r_u_pos;
    logic            w_u_look_rd;
    logic            w_u_shift_rd;
    logic            w_u_rd;
    logic [UIW-1:0]  w_u_idx_dec;
    logic [UW-1:0]   w_u_raddr;
    logic            w_u_we;
    logic [UW-1:0]   w_u_waddr;
    logic [EW-1:0]   w_u_wdata;
    logic [UIDW-1:0] w_ruid;
    logic [PW-1:0]   w_rpeer;

    // output register
    logic            r_o_valid;
    logic [PW-1:0]   r_o_dest;
    logic            r_o_has;
    logic [TW-1:0]   r_o_tag;
    logic [1:0]      r_o_status;
    logic            r_o_last;
    logic            w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auth_req <= 1'b1;
        end else if (i_cfg_we) begin
            r_auth_req <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_in.req_type;
            r_peer <= i_in.peer_id;
            r_uid  <= i_in.uid;
            r_tag  <= i_in.packet_tag;
        end
    end

    // ---------------- authorized list ----------------
    assign w_a_rd   = i_cmd.auth_step && (r_a_idx < A_DEPTH);
    assign w_a_addr = r_a_idx[AW-1:0];
    assign w_a_done = (r_a_idx == A_DEPTH) && !r_a_pend;

    always_ff @(posedge i_clk) begin
        if (w_a_rd) r_auth_rdata <= r_auth_mem[w_a_addr];
        if (i_cmd.auth_write) r_auth_mem[r_a_fidx] <= r_peer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auth_valid <= '0;
            r_a_idx      <= '0;
            r_a_pend     <= 1'b0;
            r_a_hit      <= 1'b0;
            r_a_free     <= 1'b0;
        end else begin
            if (i_cmd.auth_clear) begin
                r_auth_valid <= '0;
            end else if (i_cmd.auth_write) begin
                r_auth_valid[r_a_fidx] <= 1'b1;
            end
            if (i_cmd.auth_start) begin
                r_a_idx  <= '0;
                r_a_pend <= 1'b0;
                r_a_hit  <= 1'b0;
                r_a_free <= 1'b0;
            end else begin
                r_a_pend <= w_a_rd;
                if (w_a_rd) begin
                    r_a_idx <= r_a_idx + AIW'(1);
                    // remember the lowest free entry as the walk passes it
                    if (!r_auth_valid[w_a_addr] && !r_a_free) r_a_free <= 1'b1;
                end
                if (r_a_pend && r_auth_valid[r_a_pidx] && (r_auth_rdata == r_peer)) begin
                    r_a_hit <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_rd) begin
            r_a_pidx <= w_a_addr;
            if (!r_auth_valid[w_a_addr] && !r_a_free) r_a_fidx <= w_a_addr;
        end
    end

    // ---------------- multicast slot ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_m_uid   <= '0;
            r_m_peer  <= '0;
        end else if (i_cmd.mcast_update && !(r_m_valid && (r_m_uid == r_uid))) begin
            r_m_valid <= 1'b1;
            r_m_uid   <= r_uid;
            r_m_peer  <= r_peer;
        end
    end

    // ---------------- unicast table ----------------
    assign w_ruid       = r_u_rdata[EW-1:PW];
    assign w_rpeer      = r_u_rdata[PW-1:0];
    assign w_u_look_rd  = i_cmd.u_look_step && (r_u_idx < r_u_cnt);
    assign w_u_shift_rd = i_cmd.shift_step && (r_u_idx > r_u_pos);
    assign w_u_rd       = w_u_look_rd || w_u_shift_rd || i_cmd.u_read;
    assign w_u_idx_dec  = r_u_idx - UIW'(1);
    assign w_u_raddr    = i_cmd.shift_step ? w_u_idx_dec[UW-1:0] : r_u_idx[UW-1:0];
    // shift moves an entry up by one; insert drops the new entry into the gap
    assign w_u_we       = (i_cmd.shift_step && r_u_pend) || i_cmd.u_insert;
    assign w_u_waddr    = i_cmd.u_insert ? r_u_pos[UW-1:0] : r_u_pidx;
    assign w_u_wdata    = i_cmd.u_insert ? {r_uid, r_peer} : r_u_rdata;

    always_ff @(posedge i_clk) begin
        if (w_u_rd) r_u_rdata <= r_u_mem[w_u_raddr];
        if (w_u_we) r_u_mem[w_u_waddr] <= w_u_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u_cnt   <= '0;
            r_u_idx   <= '0;
            r_u_pend  <= 1'b0;
            r_u_found <= 1'b0;
            r_u_pos   <= '0;
        end else begin
            if (i_cmd.u_insert) r_u_cnt <= r_u_cnt + UIW'(1);
            if (i_cmd.u_start) begin
                r_u_idx   <= '0;
                r_u_pend  <= 1'b0;
                r_u_found <= 1'b0;
                r_u_pos   <= '0;
            end else if (i_cmd.shift_start) begin
                r_u_idx  <= r_u_cnt;
                r_u_pend <= 1'b0;
            end else begin
                r_u_pend <= w_u_look_rd || w_u_shift_rd;
                if (w_u_look_rd || i_cmd.u_read) begin
                    r_u_idx <= r_u_idx + UIW'(1);
                end else if (w_u_shift_rd) begin
                    r_u_idx <= w_u_idx_dec;
                end
                if (i_cmd.u_look_step && r_u_pend) begin
                    if (w_ruid == r_uid) r_u_found <= 1'b1;
                    // count smaller uids to find the insert position
                    if (w_ruid < r_uid) r_u_pos <= r_u_pos + UIW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_u_shift_rd) r_u_pidx <= r_u_idx[UW-1:0];
    end

    // ---------------- output register ----------------
    assign w_out_free = !r_o_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_tag    <= r_tag;
            r_o_status <= i_cmd.emit_status;
            r_o_last   <= i_cmd.emit_last;
            case (i_cmd.emit_sel)
                rgfr_pkg::SEL_UCAST: begin
                    r_o_dest <= w_rpeer;
                    r_o_has  <= 1'b1;
                end
                rgfr_pkg::SEL_MCAST: begin
                    r_o_dest <= r_m_valid ? r_m_peer : '0;
                    r_o_has  <= r_m_valid;
                end
                default: begin
                    r_o_dest <= '0;
                    r_o_has  <= 1'b0;
                end
            endcase
        end
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.dest_peer = r_o_dest;
    assign o_out.has_dest  = r_o_has;
    assign o_out.out_tag   = r_o_tag;
    assign o_out.status    = r_o_status;
    assign o_out.last      = r_o_last;

    // ---------------- status to controller ----------------
    always_comb begin
        o_stat            = '0;
        o_stat.req        = r_req;
        o_stat.uid_odd    = r_uid[0];
        o_stat.auth_req   = r_auth_req;
        o_stat.auth_done  = w_a_done;
        o_stat.auth_hit   = r_a_hit;
        o_stat.auth_free  = r_a_free;
        o_stat.look_done  = (r_u_idx == r_u_cnt) && !r_u_pend;
        o_stat.u_found    = r_u_found;
        o_stat.u_full     = (r_u_cnt == U_DEPTH);
        o_stat.u_empty    = (r_u_cnt == '0);
        o_stat.shift_done = (r_u_idx == r_u_pos) && !r_u_pend;
        o_stat.emit_last  = (r_u_idx == r_u_cnt);
        o_stat.out_free   = w_out_free;
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_u_cnt <= U_DEPTH)
        else $error("unicast count beyond table depth");

    a_auth_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.auth_write |-> (w_a_done && r_a_free && !r_a_hit))
        else $error("authorized entry written without a free slot");

    a_insert_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.u_insert |-> (!r_u_found && (r_u_cnt < U_DEPTH)))
        else $error("unicast insert into full table or duplicate");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> w_out_free)
        else $error("result overwrote a waiting word");

endmodule

`default_nettype wire

[sv/relay_group_forwarding_router.sv]
// Top level of the relay group forwarding router: controller plus datapath.
// Depends on rgfr_pkg, rgfr_in_if, rgfr_out_if, rgfr_ctrl and rgfr_datapath.
//
//  channel   dir  handshake      word
//  i_in      in   valid/ready    req_type, peer_id, uid, packet_tag
//  o_out     out  valid/ready    dest_peer, has_dest, out_tag, status, last
//  cfg       in   i_cfg_we       i_cfg_wdata = auth_required
//
// One request at a time. An add, or any packet while auth_required is set, first walks
// the authorized list. An even-uid packet reads the sorted unicast table; an odd-uid
// packet looks it up, and an insert shifts each larger entry up one per cycle. Reset is
// synchronous, no clearing pass. A stalled output holds its word; the next request is
// taken while that word waits.
`default_nettype none

module relay_group_forwarding_router #(
    parameter int AUTH_DEPTH  = 16,
    parameter int UCAST_DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rgfr_in_if.sink    i_in,
    rgfr_out_if.source o_out,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata
);

    rgfr_pkg::t_cmd  w_cmd;
    rgfr_pkg::t_stat w_stat;
    logic            w_in_ready;

    assign i_in.ready = w_in_ready;

    rgfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    rgfr_datapath #(
        .AUTH_DEPTH  (AUTH_DEPTH),
        .UCAST_DEPTH (UCAST_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .o_out       (o_out),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

`default_nettype wire

[dv/rgfr_route_checker.sv]
// Checker for the relay group forwarding router: keeps its own copy of the routing
// state, predicts the result words of each accepted request and compares them in order.
// Depends on rgfr_pkg and the rgfr_in_if / rgfr_out_if channel interfaces.

module rgfr_route_checker #(
    parameter int AUTH_SLOTS = 16,
    parameter int FAN_SLOTS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rgfr_in_if   i_req,
    rgfr_out_if  i_fwd,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [rgfr_pkg::PEER_W-1:0] dest;
        logic                        has_dest;
        logic [rgfr_pkg::TAG_W-1:0]  tag;
        logic [1:0]                  status;
        logic                        last;
    } t_route_word;

    t_route_word                 route_q[$];
    t_route_word                 got;
    t_route_word                 want;
    logic                        auth_on;
    logic [rgfr_pkg::PEER_W-1:0] allow_peer [AUTH_SLOTS];
    logic                        allow_used [AUTH_SLOTS];
    logic                        src_live;
    logic [rgfr_pkg::UID_W-1:0]  src_uid;
    logic [rgfr_pkg::PEER_W-1:0] src_peer;
    logic [rgfr_pkg::UID_W-1:0]  fan_uid    [FAN_SLOTS];
    logic [rgfr_pkg::PEER_W-1:0] fan_peer   [FAN_SLOTS];
    logic                        fan_used   [FAN_SLOTS];
    int                          fail_count;
    int                          checked;

    function automatic t_route_word make_word(input logic [rgfr_pkg::PEER_W-1:0] dest,
                                              input logic has,
                                              input logic [rgfr_pkg::TAG_W-1:0] tag,
                                              input logic [1:0] st);
        t_route_word w;
        w.dest     = dest;
        w.has_dest = has;
        w.tag      = tag;
        w.status   = st;
        w.last     = 1'b0;
        return w;
    endfunction

    function automatic logic peer_allowed(input logic [rgfr_pkg::PEER_W-1:0] peer);
        for (int i = 0; i < AUTH_SLOTS; i++) begin
            if (allow_used[i] && allow_peer[i] == peer)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Work out every result word one request causes and queue them in order.
    task automatic route_request(input logic [1:0] req,
                                 input logic [rgfr_pkg::PEER_W-1:0] peer,
                                 input logic [rgfr_pkg::UID_W-1:0] uid,
                                 input logic [rgfr_pkg::TAG_W-1:0] tag);
        t_route_word                words [FAN_SLOTS];
        int                         n;
        int                         slot;
        int                         best;
        logic                       have_prev;
        logic [rgfr_pkg::UID_W-1:0] prev;
        logic                       found;
        logic [1:0]                 st;
        n         = 0;
        slot      = -1;
        best      = 0;
        have_prev = 1'b0;
        prev      = '0;
        found     = 1'b0;
        st        = rgfr_pkg::ST_OK;
        case (req)
            rgfr_pkg::REQ_CLEAR: begin
                for (int i = 0; i < AUTH_SLOTS; i++)
                    allow_used[i] = 1'b0;
                words[0] = make_word('0, 1'b0, tag, rgfr_pkg::ST_CFG);
                n = 1;
            end
            rgfr_pkg::REQ_ADD: begin
                st = rgfr_pkg::ST_CFG;
                if (!peer_allowed(peer)) begin
                    for (int i = 0; i < AUTH_SLOTS; i++) begin
                        if (slot < 0 && !allow_used[i])
                            slot = i;
                    end
                    if (slot < 0) begin
                        st = rgfr_pkg::ST_FULL;
                    end else begin
                        allow_peer[slot] = peer;
                        allow_used[slot] = 1'b1;
                    end
                end
                words[0] = make_word('0, 1'b0, tag, st);
                n = 1;
            end
            rgfr_pkg::REQ_PACKET: begin
                if (auth_on && !peer_allowed(peer)) begin
                    words[0] = make_word('0, 1'b0, tag, rgfr_pkg::ST_UNAUTH);
                    n = 1;
                end else if (!uid[0]) begin
                    // rebind the multicast slot only on a new uid
                    if (!(src_live && src_uid == uid)) begin
                        src_live = 1'b1;
                        src_uid  = uid;
                        src_peer = peer;
                    end
                    // walk unicast entries in ascending uid order
                    while (best >= 0) begin
                        best = -1;
                        for (int i = 0; i < FAN_SLOTS; i++) begin
                            if (fan_used[i] && (!have_prev || fan_uid[i] > prev) &&
                                (best < 0 || fan_uid[i] < fan_uid[best]))
                                best = i;
                        end
                        if (best >= 0) begin
                            words[n]  = make_word(fan_peer[best], 1'b1, tag,
                                                  rgfr_pkg::ST_OK);
                            n++;
                            prev      = fan_uid[best];
                            have_prev = 1'b1;
                        end
                    end
                    if (n == 0) begin
                        words[0] = make_word('0, 1'b0, tag, rgfr_pkg::ST_OK);
                        n = 1;
                    end
                end else begin
                    for (int i = 0; i < FAN_SLOTS; i++) begin
                        if (fan_used[i] && fan_uid[i] == uid)
                            found = 1'b1;
                    end
                    if (!found) begin
                        for (int i = 0; i < FAN_SLOTS; i++) begin
                            if (slot < 0 && !fan_used[i])
                                slot = i;
                        end
                        if (slot < 0) begin
                            st = rgfr_pkg::ST_FULL;
                        end else begin
                            fan_uid[slot]  = uid;
                            fan_peer[slot] = peer;
                            fan_used[slot] = 1'b1;
                        end
                    end
                    if (src_live)
                        words[0] = make_word(src_peer, 1'b1, tag, st);
                    else
                        words[0] = make_word('0, 1'b0, tag, st);
                    n = 1;
                end
            end
            default: begin
                words[0] = make_word('0, 1'b0, tag, rgfr_pkg::ST_OK);
                n = 1;
            end
        endcase
        for (int k = 0; k < n; k++) begin
            words[k].last = (k == n - 1);
            route_q.push_back(words[k]);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            auth_on    = 1'b1;
            src_live   = 1'b0;
            src_uid    = '0;
            src_peer   = '0;
            fail_count = 0;
            checked    = 0;
            for (int i = 0; i < AUTH_SLOTS; i++)
                allow_used[i] = 1'b0;
            for (int i = 0; i < FAN_SLOTS; i++)
                fan_used[i] = 1'b0;
            route_q.delete();
        end else begin
            if (i_cfg_we)
                auth_on = i_cfg_wdata;
            // compare before queuing: a word never leaves in the edge its request enters
            if (i_fwd.valid && i_fwd.ready) begin
                got      = make_word(i_fwd.dest_peer, i_fwd.has_dest, i_fwd.out_tag,
                                     i_fwd.status);
                got.last = i_fwd.last;
                if (route_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("unexpected result word: dest %h has %b tag %h st %0d last %b",
                                 got.dest, got.has_dest, got.tag, got.status, got.last);
                end else begin
                    want = route_q.pop_front();
                    checked++;
                    if (got.dest !== want.dest || got.has_dest !== want.has_dest ||
                        got.tag !== want.tag || got.status !== want.status ||
                        got.last !== want.last) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("mismatch on word %0d:", checked);
                            $display("  expected dest %h has %b tag %h st %0d last %b",
                                     want.dest, want.has_dest, want.tag, want.status,
                                     want.last);
                            $display("  actual   dest %h has %b tag %h st %0d last %b",
                                     got.dest, got.has_dest, got.tag, got.status, got.last);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                route_request(i_req.req_type, i_req.peer_id, i_req.uid, i_req.packet_tag);
        end
        o_fail_count <= fail_count;
        o_pending    <= route_q.size();
        o_checked    <= checked;
    end

endmodule

[dv/relay_group_forwarding_router_tb.sv]
// Testbench top for the relay group forwarding router: clock, reset, request stimulus,
// output back-pressure and the verdict. Depends on rgfr_pkg, the channel interfaces,
// the router and rgfr_route_checker.

module relay_group_forwarding_router_tb;

    localparam int AUTH_DEPTH    = 16;
    localparam int UCAST_DEPTH   = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 48;
    localparam int PHASE_ITEMS   = 40;
    localparam int POOL_SIZE     = 20;
    localparam int IDLE_PCT      = 28;

    localparam logic [1:0]                  REQ_UNUSED = 2'd3;
    localparam logic [rgfr_pkg::PEER_W-1:0] PEER_ZERO  = '0;
    localparam logic [rgfr_pkg::PEER_W-1:0] PEER_ONES  = '1;
    localparam logic [rgfr_pkg::PEER_W-1:0] PEER_ALT   = 64'h5555_aaaa_0f0f_f0f0;
    localparam logic [rgfr_pkg::UID_W-1:0]  UID_TOP    = '1;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic                        i_cfg_wdata;
    logic                        calm;
    int                          fail_count;
    int                          pending;
    int                          checked;
    int                          cycle_count;
    int                          sent;
    int                          cfg_writes;
    logic [rgfr_pkg::PEER_W-1:0] peer_pool [POOL_SIZE];

    rgfr_in_if  req_ch ();
    rgfr_out_if fwd_ch ();

    relay_group_forwarding_router #(
        .AUTH_DEPTH  (AUTH_DEPTH),
        .UCAST_DEPTH (UCAST_DEPTH)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (req_ch),
        .o_out       (fwd_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    rgfr_route_checker #(
        .AUTH_SLOTS (AUTH_DEPTH),
        .FAN_SLOTS  (UCAST_DEPTH)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_fwd        (fwd_ch),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        fwd_ch.ready <= i_rst_n && (calm || $urandom_range(99, 0) >= IDLE_PCT);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("relay_group_forwarding_router test failed");
        $finish;
    end

    function automatic logic [rgfr_pkg::PEER_W-1:0] rand_peer();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [rgfr_pkg::PEER_W-1:0] pick_peer();
        if ($urandom_range(99, 0) < 85)
            return peer_pool[$urandom_range(POOL_SIZE - 1, 0)];
        return rand_peer();
    endfunction

    function automatic logic [rgfr_pkg::UID_W-1:0] pick_uid();
        int roll;
        roll = $urandom_range(99, 0);
        if (roll < 40)
            return rgfr_pkg::UID_W'($urandom_range(40, 0));
        if (roll < 55)
            return $urandom_range(1, 0) ? UID_TOP - rgfr_pkg::UID_W'($urandom_range(1, 0))
                                        : rgfr_pkg::UID_W'($urandom_range(1, 0));
        return $urandom;
    endfunction

    // Present one word and hold it until the router takes it.
    task automatic send_word(input logic [1:0] req, input logic [rgfr_pkg::PEER_W-1:0] peer,
                             input logic [rgfr_pkg::UID_W-1:0] uid,
                             input logic [rgfr_pkg::TAG_W-1:0] tag);
        while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= req;
        req_ch.peer_id    <= peer;
        req_ch.uid        <= uid;
        req_ch.packet_tag <= tag;
        do @(posedge i_clk); while (!req_ch.ready);
        sent++;
    endtask

    // Drop valid, wait for every expected word, then let the router finish its walk.
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    // One setting of the register: a burst of adds, then mostly packets.
    task automatic run_phase(input logic auth_setting, input logic quiet, input logic fill);
        int burst;
        int start;
        int roll;
        write_cfg(auth_setting);
        calm  <= quiet;
        start = $urandom_range(POOL_SIZE - 1, 0);
        burst = fill ? POOL_SIZE : $urandom_range(12, 2);
        if (fill || $urandom_range(1, 0))
            send_word(rgfr_pkg::REQ_CLEAR, rand_peer(), $urandom,
                      rgfr_pkg::TAG_W'($urandom));
        for (int j = 0; j < burst; j++)
            send_word(rgfr_pkg::REQ_ADD, peer_pool[(start + j) % POOL_SIZE], $urandom,
                      rgfr_pkg::TAG_W'($urandom));
        repeat (PHASE_ITEMS - burst / 2) begin
            roll = $urandom_range(99, 0);
            if (roll < 82)
                send_word(rgfr_pkg::REQ_PACKET, pick_peer(), pick_uid(),
                          rgfr_pkg::TAG_W'($urandom));
            else if (roll < 92)
                send_word(rgfr_pkg::REQ_ADD, pick_peer(), $urandom,
                          rgfr_pkg::TAG_W'($urandom));
            else if (roll < 95)
                send_word(rgfr_pkg::REQ_CLEAR, rand_peer(), $urandom,
                          rgfr_pkg::TAG_W'($urandom));
            else
                send_word(REQ_UNUSED, rand_peer(), $urandom, rgfr_pkg::TAG_W'($urandom));
        end
        drain();
        calm <= 1'b0;
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_wdata       <= 1'b0;
        calm              <= 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= rgfr_pkg::REQ_PACKET;
        req_ch.peer_id    <= '0;
        req_ch.uid        <= '0;
        req_ch.packet_tag <= '0;
        sent       = 0;
        cfg_writes = 0;
        peer_pool[0] = PEER_ZERO;
        peer_pool[1] = PEER_ONES;
        peer_pool[2] = PEER_ALT;
        for (int i = 3; i < POOL_SIZE; i++)
            peer_pool[i] = rand_peer();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_cfg(1'b1);
        send_word(rgfr_pkg::REQ_PACKET, PEER_ZERO, 32'd5, 16'h0000);  // not yet authorized
        send_word(rgfr_pkg::REQ_ADD, PEER_ZERO, '0, 16'hffff);
        send_word(rgfr_pkg::REQ_ADD, PEER_ONES, UID_TOP, 16'h0001);
        send_word(rgfr_pkg::REQ_ADD, PEER_ZERO, '0, 16'h0002);        // already listed
        send_word(rgfr_pkg::REQ_PACKET, PEER_ZERO, 32'd1, 16'h0003);  // no multicast slot yet
        send_word(rgfr_pkg::REQ_PACKET, PEER_ONES, 32'd0, 16'h0004);
        send_word(rgfr_pkg::REQ_PACKET, PEER_ONES, UID_TOP, 16'h0005);
        send_word(rgfr_pkg::REQ_PACKET, PEER_ZERO, 32'd1, 16'h0006);  // first binding stays
        send_word(rgfr_pkg::REQ_PACKET, PEER_ZERO, 32'd0, 16'h0007);  // same even uid
        send_word(rgfr_pkg::REQ_ADD, PEER_ALT, 32'd0, 16'h0008);
        send_word(rgfr_pkg::REQ_PACKET, PEER_ALT, 32'd7, 16'h0009);
        send_word(rgfr_pkg::REQ_PACKET, PEER_ALT, UID_TOP - 1, 16'h000a);  // new multicast
        send_word(rgfr_pkg::REQ_PACKET, PEER_ZERO, 32'd3, 16'h000b);
        send_word(REQ_UNUSED, rand_peer(), $urandom, 16'h000c);
        send_word(rgfr_pkg::REQ_CLEAR, PEER_ONES, UID_TOP, 16'h000d);
        send_word(rgfr_pkg::REQ_PACKET, PEER_ZERO, 32'd0, 16'h000e);  // dropped after clear
        send_word(rgfr_pkg::REQ_ADD, PEER_ZERO, 32'd0, 16'h000f);
        send_word(rgfr_pkg::REQ_PACKET, rand_peer(), 32'd11, 16'h0010);
        drain();
        write_cfg(1'b0);
        send_word(rgfr_pkg::REQ_PACKET, rand_peer(), 32'd9, 16'h0011);
        send_word(rgfr_pkg::REQ_PACKET, rand_peer(), 32'd2, 16'h0012);
        drain();

        run_phase(1'b1, 1'b0, 1'b1);
        run_phase(1'b0, 1'b0, 1'b0);
        run_phase(1'b1, 1'b1, 1'b0);
        run_phase(1'b1, 1'b0, 1'b1);
        run_phase(1'b0, 1'b0, 1'b0);

        $display("Sent %0d requests, checked %0d result words, %0d register writes, %0d cycles.",
                 sent, checked, cfg_writes, cycle_count);
        $display("Authorization on and off, both tables driven to capacity, %0d mismatches.",
                 fail_count);
        if (fail_count == 0 && pending == 0)
            $display("relay_group_forwarding_router test passed");
        else
            $display("relay_group_forwarding_router test failed");
        $finish;
    end

endmodule

[relay_group_forwarding_router.f]
sv/rgfr_pkg.sv
sv/rgfr_in_if.sv
sv/rgfr_out_if.sv
sv/rgfr_ctrl.sv
sv/rgfr_datapath.sv
sv/relay_group_forwarding_router.sv
dv/rgfr_route_checker.sv
dv/relay_group_forwarding_router_tb.sv
